// File: design/ple_pkg.sv
package ple_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;

	// Width of a cell index and of the entry count (which must hold CAPACITY itself).
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Fixed field widths of the request and response transactions.
	localparam int OP_W   = 3;
	localparam int POS_W  = 7;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 7;

	// Common width for comparing a position against the count.
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 3'd0,
		OP_REMOVE  = 3'd1,
		OP_READ    = 3'd2,
		OP_REPLACE = 3'd3,
		OP_CLEAR   = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]   req_type;
		logic [POS_W-1:0]  position;
		logic [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic [STAT_W-1:0] status;
		logic [LEN_W-1:0]  list_length;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_WRITE
	} cell_op_t;

	// Command from the controller to the cell row; idx also selects the read word.
	typedef struct packed {
		cell_op_t              op;
		logic [IDX_W-1:0]      idx;
		logic [DATA_WIDTH-1:0] data;
	} cell_cmd_t;

endpackage

// File: design/ple_cells.sv
module ple_cells (
	input  logic                           clk,
	input  ple_pkg::cell_cmd_t             cmd,
	output logic [ple_pkg::DATA_WIDTH-1:0] rd_word
);
	import ple_pkg::*;

	logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

	// Each cell looks only at its neighbors and the broadcast command.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_ff @(posedge clk) begin
			case (cmd.op)
				CELL_INSERT: begin
					if (IDX_W'(i) == cmd.idx) begin
						cell_q[i] <= cmd.data;
					end else if (i > 0 && IDX_W'(i) > cmd.idx) begin
						cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
					end
				end
				CELL_REMOVE: begin
					if (i < CAPACITY - 1 && IDX_W'(i) >= cmd.idx) begin
						cell_q[i] <= cell_q[(i < CAPACITY - 1) ? i + 1 : i];
					end
				end
				CELL_WRITE: begin
					if (IDX_W'(i) == cmd.idx) begin
						cell_q[i] <= cmd.data;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rd_word = cell_q[cmd.idx];

endmodule

// File: design/ple_ctrl.sv
module ple_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  ple_pkg::req_t                  req,
	input  logic [ple_pkg::DATA_WIDTH-1:0] rd_word,
	output ple_pkg::cell_cmd_t             cmd,
	output ple_pkg::rsp_t                  rsp
);
	import ple_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic             full;
	logic             rd_ok;
	status_t          status;
	cell_op_t         cell_op;

	assign pos_ext = CMP_W'(req.position);
	assign cnt_ext = CMP_W'(count_q);
	assign full    = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		count_next = count_q;
		status     = ST_OK;
		cell_op    = CELL_HOLD;
		rd_ok      = 1'b0;
		case (req.req_type)
			OP_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					cell_op    = CELL_INSERT;
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				// Removing from an empty list is a no-op that still succeeds.
				if (count_q == '0) begin
					status = ST_OK;
				end else if (pos_ext >= cnt_ext) begin
					status = ST_RANGE;
				end else begin
					cell_op    = CELL_REMOVE;
					count_next = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (pos_ext >= cnt_ext) begin
					status = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			OP_REPLACE: begin
				if (pos_ext >= cnt_ext) begin
					status = ST_RANGE;
				end else begin
					cell_op = CELL_WRITE;
				end
			end
			OP_CLEAR: begin
				count_next = '0;
			end
			default: begin
				status = ST_RANGE;
			end
		endcase
	end

	assign cmd.op   = advance ? cell_op : CELL_HOLD;
	assign cmd.idx  = IDX_W'(req.position);
	assign cmd.data = DATA_WIDTH'(req.value);

	assign rsp.read_data   = rd_ok ? WORD_W'(rd_word) : '0;
	assign rsp.status      = status;
	assign rsp.list_length = LEN_W'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_next;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(count_q))
		else $error("entry count moved without an operation");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cell_op == CELL_INSERT |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list by one");

	a_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |-> cmd.op == CELL_HOLD)
		else $error("cells commanded without an operation");

endmodule

// File: design/positional_list_engine.sv
// Positional list engine: an ordered list of up to CAPACITY data words addressed
// by position, with insert, remove, read, replace and clear operations.
// Requests arrive as req transactions on req_valid/req_ready and every request
// yields exactly one rsp transaction on rsp_valid/rsp_ready, in request order.
// A request is captured into an input register, the list update and the result
// are computed from it by the cell row and the controller, and the result lands
// in the output register, from which the response is offered.
// While the receiver keeps taking responses, one request is accepted every cycle:
// each cell decides locally to shift, hold or load, so an insert or remove
// completes in a single update of the cell row wherever it lands in the list.
// When the receiver stalls, the finished response waits in the output register
// while one more request is still taken into the input register; beyond that
// req_ready drops until the response is taken.
// Reset (arst_n low) empties the list by clearing the entry count and drops
// both valid flags. The cell storage itself is not reset; cells at or beyond
// the count are never read, so no clearing pass is needed and the block is
// ready as soon as reset is released.
module positional_list_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ple_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ple_pkg::rsp_t   rsp
);
	import ple_pkg::*;

	req_t                  req_s1;
	logic                  req_valid_s1;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_next;
	logic                  advance;
	logic                  accept;
	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] rd_word;

	// The held request moves on when the output register is empty or being drained.
	assign advance   = req_valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !req_valid_s1 || advance;
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				req_valid_s1 <= 1'b1;
			end else if (advance) begin
				req_valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset; their valid flags qualify them.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	ple_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.rd_word (rd_word),
		.cmd     (cmd),
		.rsp     (rsp_next)
	);

	ple_cells u_cells (
		.clk     (clk),
		.cmd     (cmd),
		.rd_word (rd_word)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Backpressure only arises from a full input register behind a stalled output.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> req_valid_s1 && rsp_valid_q && !rsp_ready)
		else $error("input stalled without a blocked response");

	// Every accepted request is followed by a held request in the input register.
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_valid_s1)
		else $error("accepted request was lost");

	// A request that moves on always produces a response.
	a_produce: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("operation completed without a response");

endmodule
